// ----- rtl/core/arq_pkg.sv -----
// ----------------------------------------------------------------------------
// arq_pkg
// Shared types and constants of the ARQ retransmit and duplicate filter
// ----------------------------------------------------------------------------
package arq_pkg;

    localparam int unsigned ID_W      = 8;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned TMO_W     = 16;
    localparam int unsigned RETRY_W   = 4;
    localparam int unsigned SLOT_O_W  = 3;
    localparam int unsigned APB_AW    = 3;
    localparam int unsigned APB_DW    = 32;

    localparam logic [TMO_W-1:0]   RESET_TIMEOUT = 16'd2000;
    localparam logic [RETRY_W-1:0] RESET_RETRIES = 4'd5;

    // register select is paddr[2]
    localparam logic REG_ACK_TIMEOUT = 1'b0;
    localparam logic REG_MAX_RETRIES = 1'b1;

    typedef enum logic [1:0] {
        ACT_SEND = 2'd0,
        ACT_DATA = 2'd1,
        ACT_ACK  = 2'd2,
        ACT_TICK = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        EV_SEND      = 4'd0,
        EV_FULL      = 4'd1,
        EV_ACK_NEW   = 4'd2,
        EV_ACK_DUP   = 4'd3,
        EV_DELIVERED = 4'd4,
        EV_UNKNOWN   = 4'd5,
        EV_RESEND    = 4'd6,
        EV_GIVEUP    = 4'd7,
        EV_DROPPED   = 4'd8,
        EV_IDLE      = 4'd9
    } t_event;

    typedef struct packed {
        t_event               ev;
        logic [ID_W-1:0]      id;
        logic [SLOT_O_W-1:0]  slot;
        logic [RETRY_W-1:0]   rl;
        logic                 last;
    } t_result;

    typedef struct packed {
        logic            start;
        logic            add;
        logic [ID_W-1:0] id;
    } t_hist_req;

    typedef struct packed {
        logic done;
        logic hit;
    } t_hist_rsp;

endpackage

// ----- rtl/core/arq_ram.sv -----
// ----------------------------------------------------------------------------
// arq_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module arq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/arq_hist.sv -----
// ----------------------------------------------------------------------------
// arq_hist
// Ring history of received ids, searched one entry per cycle
// ----------------------------------------------------------------------------
module arq_hist
    import arq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_hist_req i_req,
    output t_hist_rsp o_rsp
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic {
        H_IDLE,
        H_SRCH
    } t_hstate;

    t_hstate         r_state, n_state;
    logic [AW:0]     r_ptr, n_ptr;
    logic            r_cmp, n_cmp;
    logic [AW-1:0]   r_wpos, n_wpos;
    logic            r_wrapped, n_wrapped;
    logic [AW:0]     limit;
    logic [ID_W-1:0] rdata;

    arq_ram #(
        .WIDTH (ID_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.add),
        .i_waddr (r_wpos),
        .i_wdata (i_req.id),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (rdata)
    );

    assign limit = r_wrapped ? (AW+1)'(DEPTH) : {1'b0, r_wpos};

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_cmp     = r_cmp;
        n_wpos    = r_wpos;
        n_wrapped = r_wrapped;
        o_rsp     = '0;
        if (i_req.add) begin
            if (r_wpos == AW'(DEPTH - 1)) begin
                n_wpos    = '0;
                n_wrapped = 1'b1;
            end else begin
                n_wpos = r_wpos + 1'b1;
            end
        end
        unique case (r_state)
            H_IDLE: begin
                if (i_req.start) begin
                    n_ptr   = '0;
                    n_cmp   = 1'b0;
                    n_state = H_SRCH;
                end
            end
            H_SRCH: begin
                if (r_cmp && (rdata == i_req.id)) begin
                    o_rsp.done = 1'b1;
                    o_rsp.hit  = 1'b1;
                    n_cmp      = 1'b0;
                    n_state    = H_IDLE;
                end else if (!r_cmp && (r_ptr == limit)) begin
                    o_rsp.done = 1'b1;
                    n_state    = H_IDLE;
                end else begin
                    n_cmp = (r_ptr != limit);
                    if (r_ptr != limit) begin
                        n_ptr = r_ptr + 1'b1;
                    end
                end
            end
            default: n_state = H_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= H_IDLE;
            r_ptr     <= '0;
            r_cmp     <= 1'b0;
            r_wpos    <= '0;
            r_wrapped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_cmp     <= n_cmp;
            r_wpos    <= n_wpos;
            r_wrapped <= n_wrapped;
        end
    end

endmodule

// ----- rtl/core/arq_retransmit_and_dedup_unit.sv -----
// ----------------------------------------------------------------------------
// arq_retransmit_and_dedup_unit
// Link-layer ARQ tracker: pending slots, retransmit timer, duplicate filter
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one request per item: tuser holds the action
//   (send, data received, ack received, tick), tdata the received id and the
//   crc flag. Each item gives one or more result items on the output stream,
//   tlast marks the final one. The APB port sets the ack timeout and the
//   retry budget, and may be written only while the unit is idle.
//   An item is taken only in the idle state. A send or an ack walks the slot
//   table, one slot per cycle, and then emits its result. A data frame walks
//   the id history through its RAM, one entry per cycle. A tick takes one
//   pass to mark expired slots and one to emit them. A dropped frame goes
//   straight to emitting its result. The output is a single register; while
//   the receiver stalls, the walk stops at its next result. The last result
//   may wait while the next item is taken.
//   Reset empties all slots, clears time, id counter and history, and loads
//   the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module arq_retransmit_and_dedup_unit
    import arq_pkg::*;
#(
    parameter int unsigned QUEUE_SLOTS   = 5,
    parameter int unsigned HISTORY_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input stream
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [15:0]       i_s_axis_tdata,  // rx_id[7:0], crc_ok[8]
    input  logic [1:0]        i_s_axis_tuser,  // action[1:0]
    // output stream
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [15:0]       o_m_axis_tdata,  // msg_id[7:0], slot[10:8], retries_left[14:11]
    output logic [3:0]        o_m_axis_tuser,  // event_res[3:0]
    output logic              o_m_axis_tlast,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int unsigned SW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEND,
        S_ACK,
        S_HREQ,
        S_HIST,
        S_TSCAN,
        S_TEMIT,
        S_EMIT
    } t_state;

    t_state                 r_state, n_state;
    logic [ID_W-1:0]        r_rx, n_rx;
    logic [SW-1:0]          r_idx, n_idx;
    logic [QUEUE_SLOTS-1:0] r_exp, n_exp;
    logic [QUEUE_SLOTS-1:0] r_act, n_act;
    logic [TIME_W-1:0]      r_time, n_time;
    logic [ID_W-1:0]        r_next_id, n_next_id;
    logic [TMO_W-1:0]       r_timeout, n_timeout;
    logic [RETRY_W-1:0]     r_maxret, n_maxret;
    t_result                r_res, n_res;
    logic                   r_ovalid, n_ovalid;
    t_result                r_out, n_out;

    logic [ID_W-1:0]        r_sid   [QUEUE_SLOTS];
    logic [RETRY_W-1:0]     r_sret  [QUEUE_SLOTS];
    logic [TIME_W-1:0]      r_stime [QUEUE_SLOTS];

    logic                   we_new, we_retry;
    logic                   accept, out_free, idx_last, expired;
    logic [TIME_W-1:0]      elapsed;
    logic                   cfg_we;
    t_action                act_in;
    t_hist_req              hreq;
    t_hist_rsp              hrsp;

    arq_hist #(
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (hreq),
        .o_rsp   (hrsp)
    );

    assign act_in   = t_action'(i_s_axis_tuser);
    assign accept   = i_s_axis_tvalid && (r_state == S_IDLE);
    assign out_free = !r_ovalid || i_m_axis_tready;
    assign idx_last = (r_idx == SW'(QUEUE_SLOTS - 1));
    assign elapsed  = r_time - r_stime[r_idx];
    assign expired  = r_act[r_idx] && (elapsed >= TIME_W'(r_timeout));
    assign cfg_we   = psel && penable && pwrite;

    always_comb begin
        n_state   = r_state;
        n_rx      = r_rx;
        n_idx     = r_idx;
        n_exp     = r_exp;
        n_act     = r_act;
        n_time    = r_time;
        n_next_id = r_next_id;
        n_timeout = r_timeout;
        n_maxret  = r_maxret;
        n_res     = r_res;
        n_ovalid  = r_ovalid;
        n_out     = r_out;
        we_new    = 1'b0;
        we_retry  = 1'b0;
        hreq      = '{start: 1'b0, add: 1'b0, id: r_rx};

        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        if (cfg_we) begin
            unique case (paddr[2])
                REG_ACK_TIMEOUT: n_timeout = pwdata[TMO_W-1:0];
                REG_MAX_RETRIES: n_maxret  = pwdata[RETRY_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_rx  = i_s_axis_tdata[ID_W-1:0];
                    n_idx = '0;
                    unique case (act_in)
                        ACT_SEND: n_state = S_SEND;
                        ACT_DATA, ACT_ACK: begin
                            if (!i_s_axis_tdata[ID_W]) begin
                                n_res   = '{ev: EV_DROPPED, id: i_s_axis_tdata[ID_W-1:0],
                                            slot: '0, rl: '0, last: 1'b1};
                                n_state = S_EMIT;
                            end else if (act_in == ACT_DATA) begin
                                n_state = S_HREQ;
                            end else begin
                                n_state = S_ACK;
                            end
                        end
                        ACT_TICK: begin
                            n_time  = r_time + 1'b1;
                            n_exp   = '0;
                            n_state = S_TSCAN;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SEND: begin
                if (!r_act[r_idx]) begin
                    we_new           = 1'b1;
                    n_act[r_idx]     = 1'b1;
                    n_next_id        = r_next_id + 1'b1;
                    n_res            = '{ev: EV_SEND, id: r_next_id, slot: SLOT_O_W'(r_idx),
                                         rl: r_maxret, last: 1'b1};
                    n_state          = S_EMIT;
                end else if (idx_last) begin
                    n_res   = '{ev: EV_FULL, id: '0, slot: '0, rl: '0, last: 1'b1};
                    n_state = S_EMIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_ACK: begin
                if (r_act[r_idx] && (r_sid[r_idx] == r_rx)) begin
                    n_act[r_idx] = 1'b0;
                    n_res        = '{ev: EV_DELIVERED, id: r_rx, slot: SLOT_O_W'(r_idx),
                                     rl: r_sret[r_idx], last: 1'b1};
                    n_state      = S_EMIT;
                end else if (idx_last) begin
                    n_res   = '{ev: EV_UNKNOWN, id: r_rx, slot: '0, rl: '0, last: 1'b1};
                    n_state = S_EMIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_HREQ: begin
                hreq.start = 1'b1;
                n_state    = S_HIST;
            end
            S_HIST: begin
                if (hrsp.done) begin
                    hreq.add = !hrsp.hit;
                    n_res    = '{ev: EV_ACK_NEW, id: r_rx, slot: '0, rl: '0, last: 1'b1};
                    if (hrsp.hit) begin
                        n_res.ev = EV_ACK_DUP;
                    end
                    n_state  = S_EMIT;
                end
            end
            S_TSCAN: begin
                n_exp[r_idx] = expired;
                if (idx_last) begin
                    n_idx = '0;
                    if (n_exp == '0) begin
                        n_res   = '{ev: EV_IDLE, id: '0, slot: '0, rl: '0, last: 1'b1};
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_TEMIT;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_TEMIT: begin
                if (r_exp[r_idx]) begin
                    n_exp[r_idx] = 1'b0;
                    if (r_sret[r_idx] != '0) begin
                        we_retry = 1'b1;
                        n_res    = '{ev: EV_RESEND, id: r_sid[r_idx], slot: SLOT_O_W'(r_idx),
                                     rl: r_sret[r_idx] - 1'b1, last: 1'b0};
                    end else begin
                        n_act[r_idx] = 1'b0;
                        n_res        = '{ev: EV_GIVEUP, id: r_sid[r_idx],
                                         slot: SLOT_O_W'(r_idx), rl: '0, last: 1'b0};
                    end
                    n_res.last = (n_exp == '0);
                    n_state    = S_EMIT;
                end
                if (!idx_last) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out    = r_res;
                    n_state  = r_res.last ? S_IDLE : S_TEMIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_exp     <= '0;
            r_act     <= '0;
            r_time    <= '0;
            r_next_id <= '0;
            r_timeout <= RESET_TIMEOUT;
            r_maxret  <= RESET_RETRIES;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_exp     <= n_exp;
            r_act     <= n_act;
            r_time    <= n_time;
            r_next_id <= n_next_id;
            r_timeout <= n_timeout;
            r_maxret  <= n_maxret;
            r_ovalid  <= n_ovalid;
        end
        r_rx  <= n_rx;
        r_res <= n_res;
        r_out <= n_out;
    end

    // slot payload, written at the walk index
    always_ff @(posedge i_clk) begin
        if (we_new) begin
            r_sid[r_idx]   <= r_next_id;
            r_sret[r_idx]  <= r_maxret;
            r_stime[r_idx] <= r_time;
        end else if (we_retry) begin
            r_sret[r_idx]  <= r_sret[r_idx] - 1'b1;
            r_stime[r_idx] <= r_time;
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_ACK_TIMEOUT: prdata = APB_DW'(r_timeout);
            REG_MAX_RETRIES: prdata = APB_DW'(r_maxret);
            default: prdata = '0;
        endcase
    end

    assign pready          = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {1'b0, r_out.rl, r_out.slot, r_out.id};
    assign o_m_axis_tuser  = r_out.ev;
    assign o_m_axis_tlast  = r_out.last;

endmodule

// ----- sim/arq_retransmit_and_dedup_unit_tb.sv -----
// ----------------------------------------------------------------------------
// arq_retransmit_and_dedup_unit_tb
// Self-checking bench for the ARQ tracker: a directed table of requests
// (slot fill, queue full, ack hit and miss, bad crc, duplicates, expiry with
// resend and give-up, zero and maximum timeout) followed by random phases,
// each under its own register setting. Every result item is compared with a
// behavioral copy of the slot table, the id history and the tick counter.
// Both streams idle at random; the receiver also holds off for a long stretch.
// ----------------------------------------------------------------------------
module arq_retransmit_and_dedup_unit_tb;
    import arq_pkg::*;

    localparam int NSLOT = 5;
    localparam int NHIST = 16;
    localparam int PHASE_ITEMS = 40;
    localparam int NPHASE = 8;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [15:0]       i_s_axis_tdata;  // rx_id[7:0], crc_ok[8]
    logic [1:0]        i_s_axis_tuser;  // action[1:0]
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [15:0]       o_m_axis_tdata;  // msg_id[7:0], slot[10:8], retries_left[14:11]
    logic [3:0]        o_m_axis_tuser;  // event_res[3:0]
    logic              o_m_axis_tlast;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    arq_retransmit_and_dedup_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    typedef struct {
        bit          is_reg;
        logic        reg_sel;
        logic [15:0] reg_val;
        t_action     act;
        logic [7:0]  rx;
        logic        crc;
        bit          known;
        t_result     want;
    } t_row;

    // tracker copy
    logic [TMO_W-1:0]   cfg_timeout;
    logic [RETRY_W-1:0] cfg_retries;
    bit                 pend_active [NSLOT];
    logic [7:0]         pend_id     [NSLOT];
    logic [3:0]         pend_retries[NSLOT];
    logic [31:0]        pend_stamp  [NSLOT];
    logic [31:0]        now_ticks;
    logic [7:0]         id_counter;
    logic [7:0]         hist_ids[NHIST];
    int                 hist_wr;
    bit                 hist_full;

    t_result events_new[$];
    t_result events_due[$];
    t_result head;
    t_row    plan[$];
    int      mismatches;
    int      items_sent;
    int      results_seen;

    function automatic void note_event(t_event ev, logic [7:0] id, logic [2:0] sl,
                                       logic [3:0] rl);
        t_result r;
        r.ev   = ev;
        r.id   = id;
        r.slot = sl;
        r.rl   = rl;
        r.last = 1'b0;
        events_new.push_back(r);
    endfunction

    function automatic void track_item(t_action act, logic [7:0] rx, logic crc);
        int   hit;
        int   span;
        bit   dup;
        logic [31:0] elapsed;
        events_new.delete();
        hit = -1;
        dup = 1'b0;
        case (act)
            ACT_SEND: begin
                for (int i = 0; i < NSLOT; i++)
                    if (!pend_active[i] && hit < 0) hit = i;
                if (hit < 0) begin
                    note_event(EV_FULL, 8'd0, 3'd0, 4'd0);
                end else begin
                    pend_active[hit]  = 1'b1;
                    pend_id[hit]      = id_counter;
                    pend_retries[hit] = cfg_retries;
                    pend_stamp[hit]   = now_ticks;
                    note_event(EV_SEND, id_counter, 3'(hit), cfg_retries);
                    id_counter = id_counter + 8'd1;
                end
            end
            ACT_DATA, ACT_ACK: begin
                if (!crc) begin
                    note_event(EV_DROPPED, rx, 3'd0, 4'd0);
                end else if (act == ACT_DATA) begin
                    span = hist_full ? NHIST : hist_wr;
                    for (int i = 0; i < span; i++)
                        if (hist_ids[i] == rx) dup = 1'b1;
                    if (dup) begin
                        note_event(EV_ACK_DUP, rx, 3'd0, 4'd0);
                    end else begin
                        hist_ids[hist_wr] = rx;
                        hist_wr = (hist_wr + 1) % NHIST;
                        if (hist_wr == 0) hist_full = 1'b1;
                        note_event(EV_ACK_NEW, rx, 3'd0, 4'd0);
                    end
                end else begin
                    for (int i = 0; i < NSLOT; i++)
                        if (pend_active[i] && pend_id[i] == rx && hit < 0) hit = i;
                    if (hit < 0) begin
                        note_event(EV_UNKNOWN, rx, 3'd0, 4'd0);
                    end else begin
                        pend_active[hit] = 1'b0;
                        note_event(EV_DELIVERED, rx, 3'(hit), pend_retries[hit]);
                    end
                end
            end
            default: begin
                now_ticks = now_ticks + 32'd1;
                for (int i = 0; i < NSLOT; i++) begin
                    elapsed = now_ticks - pend_stamp[i];
                    if (pend_active[i] && elapsed >= {16'd0, cfg_timeout}) begin
                        if (pend_retries[i] != 4'd0) begin
                            pend_retries[i] = pend_retries[i] - 4'd1;
                            pend_stamp[i]   = now_ticks;
                            note_event(EV_RESEND, pend_id[i], 3'(i), pend_retries[i]);
                        end else begin
                            pend_active[i] = 1'b0;
                            note_event(EV_GIVEUP, pend_id[i], 3'(i), 4'd0);
                        end
                    end
                end
                if (events_new.size() == 0) note_event(EV_IDLE, 8'd0, 3'd0, 4'd0);
            end
        endcase
        events_new[events_new.size()-1].last = 1'b1;
    endfunction

    function automatic t_row step_row(t_action act, logic [7:0] rx, logic crc);
        t_row r;
        r.is_reg  = 1'b0;
        r.reg_sel = 1'b0;
        r.reg_val = '0;
        r.act     = act;
        r.rx      = rx;
        r.crc     = crc;
        r.known   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic t_row known_row(t_action act, logic [7:0] rx, logic crc,
                                       t_event ev, logic [7:0] id, logic [2:0] sl,
                                       logic [3:0] rl);
        t_row r;
        r = step_row(act, rx, crc);
        r.known     = 1'b1;
        r.want.ev   = ev;
        r.want.id   = id;
        r.want.slot = sl;
        r.want.rl   = rl;
        r.want.last = 1'b1;
        return r;
    endfunction

    function automatic t_row reg_row(logic sel, logic [15:0] val);
        t_row r;
        r = step_row(ACT_TICK, 8'd0, 1'b0);
        r.is_reg  = 1'b1;
        r.reg_sel = sel;
        r.reg_val = val;
        return r;
    endfunction

    task automatic offer_item(t_action act, logic [7:0] rx, logic crc, bit known,
                              t_result want);
        int gap;
        gap = (((items_sent / 32) % 3) == 1) ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tdata  <= {7'd0, crc, rx};
        i_s_axis_tuser  <= act;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
        track_item(act, rx, crc);
        if (known) events_due.push_back(want);
        else foreach (events_new[k]) events_due.push_back(events_new[k]);
    endtask

    task automatic write_reg(logic sel, logic [15:0] val);
        i_s_axis_tvalid <= 1'b0;
        while (events_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (sel == REG_ACK_TIMEOUT) cfg_timeout = val;
        else cfg_retries = val[RETRY_W-1:0];
    endtask

    task automatic random_phase(int count);
        t_action    act;
        logic [7:0] rx;
        logic       crc;
        logic [7:0] live[$];
        int         pick;
        t_result    none;
        none = '0;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            rx   = 8'($urandom);
            crc  = ($urandom_range(0, 9) != 0);
            if (pick < 30) begin
                act = ACT_SEND;
            end else if (pick < 52) begin
                act = ACT_ACK;
                live.delete();
                for (int i = 0; i < NSLOT; i++)
                    if (pend_active[i]) live.push_back(pend_id[i]);
                if (live.size() != 0 && $urandom_range(0, 3) != 0)
                    rx = live[$urandom_range(0, live.size() - 1)];
            end else if (pick < 74) begin
                act = ACT_DATA;
                if ($urandom_range(0, 1) == 0) rx = 8'hC0 + 8'($urandom_range(0, 23));
            end else begin
                act = ACT_TICK;
            end
            offer_item(act, rx, crc, 1'b0, none);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen <= results_seen + 1;
            if (events_due.size() == 0) begin
                $error("result item with none due: event %0d id %0d", o_m_axis_tuser,
                       o_m_axis_tdata[7:0]);
                mismatches++;
            end else begin
                head = events_due.pop_front();
                if (4'(head.ev) !== o_m_axis_tuser) begin
                    $error("event_res exp %0d got %0d", head.ev, o_m_axis_tuser);
                    mismatches++;
                end
                if (head.id !== o_m_axis_tdata[7:0]) begin
                    $error("msg_id exp %0d got %0d", head.id, o_m_axis_tdata[7:0]);
                    mismatches++;
                end
                if (head.slot !== o_m_axis_tdata[10:8]) begin
                    $error("slot exp %0d got %0d", head.slot, o_m_axis_tdata[10:8]);
                    mismatches++;
                end
                if (head.rl !== o_m_axis_tdata[14:11]) begin
                    $error("retries_left exp %0d got %0d", head.rl, o_m_axis_tdata[14:11]);
                    mismatches++;
                end
                if (head.last !== o_m_axis_tlast) begin
                    $error("last_result exp %0d got %0d", head.last, o_m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // receiver: random stalls, calm stretches, one long hold-off
    initial begin
        int gap;
        int got;
        bit held;
        got  = 0;
        held = 1'b0;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!held && got >= 120) begin
                gap  = 300;
                held = 1'b1;
            end else begin
                gap = (((got / 24) % 3) == 2) ? 0 : $urandom_range(0, 7);
            end
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            got++;
        end
    end

    initial begin
        #(12 * 300000);
        $display("arq_retransmit_and_dedup_unit regression: fail");
        $finish;
    end

    initial begin
        logic [15:0] tmo;
        logic [15:0] rty;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        mismatches      = 0;
        items_sent      = 0;
        results_seen    = 0;
        cfg_timeout     = 16'd2000;
        cfg_retries     = 4'd5;
        now_ticks       = '0;
        id_counter      = '0;
        hist_wr         = 0;
        hist_full       = 1'b0;
        foreach (pend_active[i]) pend_active[i] = 1'b0;

        plan.push_back(known_row(ACT_TICK, 8'h00, 1'b1, EV_IDLE, 8'd0, 3'd0, 4'd0));
        for (int i = 0; i < NSLOT; i++)
            plan.push_back(known_row(ACT_SEND, 8'h00, 1'b1, EV_SEND, 8'(i), 3'(i), 4'd5));
        plan.push_back(known_row(ACT_SEND, 8'h00, 1'b1, EV_FULL, 8'd0, 3'd0, 4'd0));
        plan.push_back(known_row(ACT_ACK, 8'h02, 1'b1, EV_DELIVERED, 8'd2, 3'd2, 4'd5));
        plan.push_back(known_row(ACT_SEND, 8'h00, 1'b1, EV_SEND, 8'd5, 3'd2, 4'd5));
        plan.push_back(known_row(ACT_ACK, 8'hFF, 1'b0, EV_DROPPED, 8'hFF, 3'd0, 4'd0));
        plan.push_back(known_row(ACT_DATA, 8'h00, 1'b0, EV_DROPPED, 8'h00, 3'd0, 4'd0));
        plan.push_back(known_row(ACT_ACK, 8'hAA, 1'b1, EV_UNKNOWN, 8'hAA, 3'd0, 4'd0));
        plan.push_back(known_row(ACT_DATA, 8'hFF, 1'b1, EV_ACK_NEW, 8'hFF, 3'd0, 4'd0));
        plan.push_back(known_row(ACT_DATA, 8'hFF, 1'b1, EV_ACK_DUP, 8'hFF, 3'd0, 4'd0));
        plan.push_back(known_row(ACT_DATA, 8'h00, 1'b1, EV_ACK_NEW, 8'h00, 3'd0, 4'd0));
        plan.push_back(step_row(ACT_DATA, 8'h55, 1'b1));
        plan.push_back(step_row(ACT_DATA, 8'h55, 1'b1));
        plan.push_back(reg_row(REG_ACK_TIMEOUT, 16'd1));
        plan.push_back(step_row(ACT_TICK, 8'h00, 1'b0));
        plan.push_back(reg_row(REG_MAX_RETRIES, 16'd0));
        plan.push_back(step_row(ACT_ACK, 8'h00, 1'b1));
        plan.push_back(step_row(ACT_SEND, 8'h00, 1'b0));
        plan.push_back(step_row(ACT_TICK, 8'h00, 1'b0));
        plan.push_back(reg_row(REG_ACK_TIMEOUT, 16'd0));
        plan.push_back(step_row(ACT_TICK, 8'h00, 1'b0));
        plan.push_back(step_row(ACT_TICK, 8'h00, 1'b0));
        plan.push_back(reg_row(REG_ACK_TIMEOUT, 16'hFFFF));
        plan.push_back(reg_row(REG_MAX_RETRIES, 16'd15));
        plan.push_back(step_row(ACT_SEND, 8'h00, 1'b1));
        plan.push_back(step_row(ACT_TICK, 8'h00, 1'b1));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].is_reg) write_reg(plan[k].reg_sel, plan[k].reg_val);
            else offer_item(plan[k].act, plan[k].rx, plan[k].crc, plan[k].known,
                            plan[k].want);
        end

        for (int ph = 0; ph < NPHASE; ph++) begin
            case (ph)
                0: begin tmo = 16'd2;                     rty = 16'd3;  end
                1: begin tmo = 16'd0;                     rty = 16'd15; end
                2: begin tmo = 16'hFFFF;                  rty = 16'd1;  end
                3: begin tmo = 16'd1;                     rty = 16'd0;  end
                4: begin tmo = 16'd2000;                  rty = 16'd5;  end
                5: begin tmo = 16'($urandom_range(1, 6)); rty = 16'($urandom_range(0, 15)); end
                6: begin tmo = 16'd4;                     rty = 16'd2;  end
                default: begin
                    tmo = 16'($urandom_range(0, 3));
                    rty = 16'd15;
                end
            endcase
            write_reg(REG_ACK_TIMEOUT, tmo);
            write_reg(REG_MAX_RETRIES, rty);
            random_phase(PHASE_ITEMS);
        end

        i_s_axis_tvalid <= 1'b0;
        while (events_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("arq_retransmit_and_dedup_unit regression: pass");
        end else begin
            $display("arq_retransmit_and_dedup_unit regression: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/arq_pkg.sv
rtl/core/arq_ram.sv
rtl/core/arq_hist.sv
rtl/core/arq_retransmit_and_dedup_unit.sv
sim/arq_retransmit_and_dedup_unit_tb.sv
